// File: design/lfu_pkg.sv
// shared types and constants for the lfu cache table
// holds table sizing, the scan beat carried along the cell row and the update broadcast
package lfu_pkg;

  localparam int ENTRIES = 16;
  localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int KW      = 32;
  localparam int VW      = 32;
  localparam int NW      = 32;
  localparam int SW      = 64;
  localparam int CAPW    = 5;

  localparam logic [CAPW-1:0] CAP_RESET = CAPW'(16);
  localparam logic [NW-1:0]   CNT_MAX   = '1;
  localparam logic [VW-1:0]   MISS_VAL  = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  // search beat handed from cell to cell
  typedef struct packed {
    logic          tok;
    logic [KW-1:0] key;
    logic          match;
    logic [IW-1:0] match_idx;
    logic [VW-1:0] match_val;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic [CW-1:0] used;
    logic          vic_found;
    logic [IW-1:0] vic_idx;
    logic [NW-1:0] vic_cnt;
    logic [SW-1:0] vic_stamp;
  } scan_t;

  // write broadcast from the controller to all cells
  typedef struct packed {
    logic          en;
    logic [IW-1:0] idx;
    logic          ins;
    logic          wr_val;
    logic [KW-1:0] key;
    logic [VW-1:0] value;
    logic [SW-1:0] stamp;
  } upd_t;

endpackage

// File: design/lfu_cell.sv
// one table entry of the lfu cache with its stage of the search chain
// depends on lfu_pkg for the scan beat and update types
module lfu_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [lfu_pkg::IW-1:0]   cell_idx,
  input  lfu_pkg::scan_t           scan_in,
  output lfu_pkg::scan_t           scan_out,
  input  lfu_pkg::upd_t            upd
);
  import lfu_pkg::*;

  logic          valid_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;
  logic [NW-1:0] cnt_r;
  logic [SW-1:0] stamp_r;
  logic          tok_r;
  scan_t         scan_r;
  scan_t         scan_nxt;
  logic          sel;
  logic          better;

  // fold this entry into the passing search beat
  always_comb begin
    scan_nxt = scan_in;
    better   = valid_r && (!scan_in.vic_found || (cnt_r < scan_in.vic_cnt) ||
               ((cnt_r == scan_in.vic_cnt) && (stamp_r < scan_in.vic_stamp)));
    if (valid_r && (key_r == scan_in.key) && !scan_in.match) begin
      scan_nxt.match     = 1'b1;
      scan_nxt.match_idx = cell_idx;
      scan_nxt.match_val = val_r;
    end
    if (!valid_r && !scan_in.free_found) begin
      scan_nxt.free_found = 1'b1;
      scan_nxt.free_idx   = cell_idx;
    end
    if (valid_r) begin
      scan_nxt.used = scan_in.used + CW'(1);
    end
    if (better) begin
      scan_nxt.vic_found = 1'b1;
      scan_nxt.vic_idx   = cell_idx;
      scan_nxt.vic_cnt   = cnt_r;
      scan_nxt.vic_stamp = stamp_r;
    end
  end

  // beat marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= scan_in.tok;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (scan_in.tok) begin
      scan_r <= scan_nxt;
    end
  end

  always_comb begin
    scan_out     = scan_r;
    scan_out.tok = tok_r;
  end

  assign sel = upd.en && (upd.idx == cell_idx);

  // entry valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel && upd.ins) begin
      valid_r <= 1'b1;
    end
  end

  // entry contents: insert or touch
  always_ff @(posedge clk) begin
    if (sel) begin
      stamp_r <= upd.stamp;
      if (upd.ins) begin
        key_r <= upd.key;
        val_r <= upd.value;
        cnt_r <= NW'(1);
      end else begin
        if (upd.wr_val) begin
          val_r <= upd.value;
        end
        if (cnt_r != CNT_MAX) begin
          cnt_r <= cnt_r + NW'(1);
        end
      end
    end
  end

endmodule

// File: design/lfu_cache_table.sv
// lfu cache table top level: entry cell row from lfu_cell, types from lfu_pkg
// the search beat walks the cell row, registered in every cell; at the tail res_r latches
// the search, and the apply state applies it and loads the result register
// one beat at a time: the next beat is accepted only after the apply of the last one;
// the apply stalls while the result register still holds an unaccepted beat
// reset (rst_n, synchronous) empties the table, clears the access clock and sets capacity 16
module lfu_cache_table (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,     // capacity
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // key [31:0], value [63:32]
  input  logic        in_tuser,      // opcode
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // hit [0], read_value [32:1], evicted [33], zero fill
);
  import lfu_pkg::*;

  state_t          state_r, state_nxt;
  logic [CAPW-1:0] cap_r;
  logic            op_r;
  logic [KW-1:0]   key_r;
  logic [VW-1:0]   val_r;
  scan_t           res_r;
  logic [SW-1:0]   clock_r, clock_nxt;
  logic            out_valid_r;
  logic [39:0]     out_data_r;
  logic            in_acc;
  logic            apply_go;
  logic [31:0]     cap_eff;
  logic            full;
  logic            hit;
  logic [VW-1:0]   rd;
  logic            ev;
  upd_t            upd;
  scan_t           chain [0:ENTRIES];

  assign in_acc = in_tvalid && in_tready;

  // head of the search chain: a fresh beat on acceptance
  always_comb begin
    chain[0]     = '0;
    chain[0].tok = in_acc;
    chain[0].key = in_tdata[KW-1:0];
  end

  // row of entry cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IW'(g)),
      .scan_in  (chain[g]),
      .scan_out (chain[g+1]),
      .upd      (upd)
    );
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // captured request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      key_r <= in_tdata[KW-1:0];
      val_r <= in_tdata[KW+VW-1:KW];
    end
  end

  // captured search result at the tail of the row
  always_ff @(posedge clk) begin
    if (chain[ENTRIES].tok) begin
      res_r <= chain[ENTRIES];
    end
  end

  assign cap_eff = (32'(cap_r) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(cap_r);
  assign full    = (32'(res_r.used) >= cap_eff) || !res_r.free_found;

  // decision and update broadcast
  always_comb begin
    hit       = res_r.match;
    rd        = '0;
    ev        = 1'b0;
    clock_nxt = clock_r;
    upd       = '0;
    upd.key   = key_r;
    upd.value = val_r;
    upd.stamp = clock_r;
    if (op_t'(op_r) == OP_GET) begin
      if (res_r.match) begin
        rd         = res_r.match_val;
        upd.en     = 1'b1;
        upd.idx    = res_r.match_idx;
        clock_nxt  = clock_r + SW'(1);
      end else begin
        rd = MISS_VAL;
      end
    end else if (cap_eff != 32'd0) begin
      if (res_r.match) begin
        upd.en     = 1'b1;
        upd.idx    = res_r.match_idx;
        upd.wr_val = 1'b1;
        clock_nxt  = clock_r + SW'(1);
      end else if (full) begin
        ev         = 1'b1;
        upd.en     = res_r.vic_found;
        upd.idx    = res_r.vic_idx;
        upd.ins    = 1'b1;
        clock_nxt  = res_r.vic_found ? clock_r + SW'(1) : clock_r;
      end else begin
        upd.en     = 1'b1;
        upd.idx    = res_r.free_idx;
        upd.ins    = 1'b1;
        clock_nxt  = clock_r + SW'(1);
      end
    end
    apply_go = (state_r == ST_APPLY) && (!out_valid_r || out_tready);
    upd.en   = upd.en && apply_go;
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[ENTRIES].tok) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // access clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
    end else if (apply_go) begin
      clock_r <= clock_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_data_r <= {6'b0, ev, rd, hit};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the lfu cache table
// depends on lfu_pkg and lfu_cache_table; predicts every result beat in-line
`timescale 1ns / 1ps

module tb_top;
  import lfu_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_SIZE   = 24;

  // result fields laid out as on out_tdata, lowest bit last
  typedef struct packed {
    logic          evicted;
    logic [VW-1:0] read_value;
    logic          hit;
  } lookup_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CAPW-1:0]  cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [63:0]      in_tdata = '0;   // key [31:0], value [63:32]
  logic             in_tuser = 1'b0; // opcode
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [39:0]      out_tdata;       // hit [0], read_value [32:1], evicted [33]

  // shadow copy of the table
  logic             tbl_valid [ENTRIES];
  logic [KW-1:0]    tbl_key   [ENTRIES];
  logic [VW-1:0]    tbl_val   [ENTRIES];
  logic [NW-1:0]    tbl_cnt   [ENTRIES];
  logic [SW-1:0]    tbl_stamp [ENTRIES];
  logic [SW-1:0]    stamp_clock;
  logic [CAPW-1:0]  cap_reg;

  lookup_res_t      expected_lookups [$];
  logic [KW-1:0]    key_pool [POOL_SIZE];
  int               err_count = 0;
  int               cycle_count = 0;
  int               long_hold_req = 0;
  bit               tx_idle_on = 1'b0;
  bit               rx_idle_on = 1'b0;

  lfu_cache_table dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_tvalid             (in_tvalid),
    .in_tready             (in_tready),
    .in_tdata              (in_tdata),
    .in_tuser              (in_tuser),
    .out_tvalid            (out_tvalid),
    .out_tready            (out_tready),
    .out_tdata             (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_table();
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    stamp_clock = '0;
    cap_reg     = CAP_RESET;
  endfunction

  // count up with saturation and take a fresh stamp
  function automatic void touch_entry(input int i);
    if (tbl_cnt[i] != CNT_MAX) tbl_cnt[i] = tbl_cnt[i] + 1'b1;
    tbl_stamp[i] = stamp_clock;
    stamp_clock  = stamp_clock + 1'b1;
  endfunction

  // lowest count, oldest stamp on ties; -1 on an empty table
  function automatic int least_used_slot();
    int v;
    v = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && (v < 0 || tbl_cnt[i] < tbl_cnt[v] ||
          (tbl_cnt[i] == tbl_cnt[v] && tbl_stamp[i] < tbl_stamp[v])))
        v = i;
    return v;
  endfunction

  function automatic lookup_res_t apply_access(input op_t op, input logic [KW-1:0] k,
                                               input logic [VW-1:0] v);
    lookup_res_t r;
    int found, slot, used, lim;
    found = -1;
    slot  = -1;
    used  = 0;
    lim   = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && tbl_valid[i] && tbl_key[i] == k) found = i;
    r.hit        = (found >= 0);
    r.read_value = '0;
    r.evicted    = 1'b0;
    if (op == OP_GET) begin
      if (found >= 0) begin
        r.read_value = tbl_val[found];
        touch_entry(found);
      end else begin
        r.read_value = MISS_VAL;
      end
    end else if (lim != 0) begin
      if (found >= 0) begin
        tbl_val[found] = v;
        touch_entry(found);
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i]) used++;
          else if (slot < 0) slot = i;
        end
        // full at the current capacity: replace the least used entry
        if (used >= lim || slot < 0) begin
          slot      = least_used_slot();
          r.evicted = 1'b1;
        end
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b1;
          tbl_key[slot]   = k;
          tbl_val[slot]   = v;
          tbl_cnt[slot]   = 1;
          tbl_stamp[slot] = stamp_clock;
          stamp_clock     = stamp_clock + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- result side

  function automatic void check_result(input logic [39:0] beat);
    lookup_res_t got, want;
    got = lookup_res_t'(beat[33:0]);
    if (expected_lookups.size() == 0) begin
      err_count++;
      $error("result beat with nothing expected: %h", beat);
      return;
    end
    want = expected_lookups.pop_front();
    if (got.hit !== want.hit) begin
      err_count++;
      $error("hit: expected %0d actual %0d", want.hit, got.hit);
    end
    if (got.read_value !== want.read_value) begin
      err_count++;
      $error("read_value: expected %h actual %h", want.read_value, got.read_value);
    end
    if (got.evicted !== want.evicted) begin
      err_count++;
      $error("evicted: expected %0d actual %0d", want.evicted, got.evicted);
    end
  endfunction

  // check accepted beats, then choose the next ready level
  initial begin : result_sink
    int stall_left, hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
      if (long_hold_req != 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- request side

  task automatic send_beat(input op_t op, input logic [KW-1:0] k, input logic [VW-1:0] v);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {v, k};
    do @(posedge clk); while (!in_tready);
    expected_lookups.push_back(apply_access(op, k, v));
  endtask

  // capacity changes only once the table has drained
  task automatic set_capacity(input logic [CAPW-1:0] c);
    in_tvalid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_reg   = c;
  endtask

  // mostly keys from a small pool so that hits and evictions are frequent
  function automatic logic [KW-1:0] pick_key(input int span);
    if ($urandom_range(0, 15) == 0) return $urandom;
    return key_pool[$urandom_range(0, span - 1)];
  endfunction

  task automatic run_traffic(input int beats, input int span, input int put_pct);
    op_t op;
    for (int n = 0; n < beats; n++) begin
      op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
      send_beat(op, pick_key(span), $urandom);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // extreme keys and values, miss on empty table, update of a present key
  task automatic test_extremes();
    send_beat(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_beat(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_beat(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_beat(OP_PUT, 32'h0000_0000, 32'h1234_5678);
    send_beat(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_GET, 32'h0000_0001, 32'h0000_0000);
  endtask

  // full table: lowest count goes first, then the oldest among equal counts
  task automatic test_replacement();
    set_capacity(5'd4);
    send_beat(OP_PUT, 32'h0000_0055, 32'hA5A5_A5A5);
    send_beat(OP_GET, 32'h0000_0055, 32'h0000_0000);
    send_beat(OP_PUT, 32'h0000_00AA, 32'h5A5A_5A5A);
    send_beat(OP_GET, 32'h8000_0000, 32'h0000_0000);
  endtask

  // zero capacity: puts change nothing but still report a present key
  task automatic test_zero_capacity();
    set_capacity(5'd0);
    send_beat(OP_PUT, 32'h0000_0000, 32'h0000_0001);
    send_beat(OP_PUT, 32'h0000_00BB, 32'h0000_0002);
    send_beat(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_GET, 32'h0000_00BB, 32'h0000_0000);
  endtask

  // capacity below occupancy: each new key replaces exactly one entry
  task automatic test_shrink();
    set_capacity(5'd1);
    send_beat(OP_PUT, 32'h0000_00CC, 32'h0000_0003);
    send_beat(OP_PUT, 32'h0000_00DD, 32'h0000_0004);
    send_beat(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_beat(OP_GET, 32'h0000_00CC, 32'h0000_0000);
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    set_capacity(5'd16);
    tx_idle_on    = 1'b0;
    long_hold_req = 300;
    run_traffic(12, 8, 50);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_full_table();
    set_capacity(5'd16);
    run_traffic(300, 24, 50);
  endtask

  // capacity values beyond the table size clamp to it
  task automatic test_random_oversize_capacity();
    set_capacity(5'd31);
    run_traffic(200, 24, 55);
    set_capacity(5'd17);
    run_traffic(150, 22, 50);
  endtask

  task automatic test_random_tiny_table();
    set_capacity(5'd3);
    run_traffic(200, 6, 50);
    set_capacity(5'd1);
    run_traffic(80, 3, 50);
  endtask

  task automatic test_random_zero_capacity();
    set_capacity(5'd16);
    run_traffic(40, 16, 80);
    set_capacity(5'd0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_traffic(80, 24, 50);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_random_shrink();
    set_capacity(5'd8);
    run_traffic(150, 12, 50);
    set_capacity(5'd2);
    run_traffic(120, 12, 50);
  endtask

  // closing stretch without any idling
  task automatic test_random_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_capacity(5'd16);
    run_traffic(250, 24, 50);
  endtask

  initial begin
    clear_table();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_extremes();
    test_replacement();
    test_zero_capacity();
    test_shrink();
    test_backpressure();
    test_random_full_table();
    test_random_oversize_capacity();
    test_random_tiny_table();
    test_random_zero_capacity();
    test_random_shrink();
    test_random_no_idle();

    // drain, then leave room for stray beats
    in_tvalid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (2 * (ENTRIES + 2)) @(posedge clk);
    if (err_count == 0 && expected_lookups.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
